/* sv/ryuv_pkg.sv */
// Shared constants and types for the RGB to YUV 4:2:0 converter.
// No dependencies; compiled first.
package ryuv_pkg;

   // Largest frame the counters and the line store are sized for.
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   localparam int PIX_W     = 8;
   localparam int CFG_W     = 12;
   localparam int CSR_IDX_W = 2;
   localparam int TERM_W    = 9;
   localparam int PAIR_W    = 2 * TERM_W;

   localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
   localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   // Width used when comparing positions against the clamped frame size.
   localparam int SIZE_W_MIN = (COL_W > ROW_W) ? COL_W + 1 : ROW_W + 1;
   localparam int SIZE_W     = (SIZE_W_MIN > CFG_W) ? SIZE_W_MIN : CFG_W;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   typedef logic [CFG_W-1:0]     cfg_word_type;
   typedef logic [PIX_W-1:0]     pix_type;

   localparam csr_index_type CSR_FRAME_WIDTH  = csr_index_type'(0);
   localparam csr_index_type CSR_FRAME_HEIGHT = csr_index_type'(1);

   localparam cfg_word_type FRAME_WIDTH_RESET  = cfg_word_type'(640);
   localparam cfg_word_type FRAME_HEIGHT_RESET = cfg_word_type'(480);

endpackage

/* sv/ryuv_if.sv */
// Valid/ready channel interfaces: pixel input, YUV result and register writes.
// Depends on ryuv_pkg.
interface ryuv_pix_if;
   import ryuv_pkg::*;
   logic    valid;
   logic    ready;
   pix_type red;
   pix_type green;
   pix_type blue;
   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface ryuv_yuv_if;
   import ryuv_pkg::*;
   logic    valid;
   logic    ready;
   pix_type luma;
   logic    chroma_valid;
   pix_type blue_diff;
   pix_type red_diff;
   logic    frame_end;
   modport source (output valid, output luma, output chroma_valid, output blue_diff,
                   output red_diff, output frame_end, input ready);
   modport sink   (input valid, input luma, input chroma_valid, input blue_diff,
                   input red_diff, input frame_end, output ready);
endinterface

interface ryuv_csr_if;
   import ryuv_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   cfg_word_type  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/ryuv_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ryuv_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 1024
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* sv/rgb_to_yuv420_box_subsample.sv */
// Top level of the RGB to YUV 4:2:0 converter with 2x2 box chroma averaging.
// Depends on ryuv_pkg, the interfaces in ryuv_if.sv and ryuv_ram.
//
//   Channel   Direction  Word                                   Handshake
//   req_pix   in         red, green, blue                       valid/ready
//   rsp_pix   out        luma, chroma_valid, blue_diff,         valid/ready
//                        red_diff, frame_end
//   csr_wr    in         index, data (frame_width, frame_height) valid/ready
//
// The block takes one pixel word per cycle while rsp_pix.ready holds, and returns one
// result word per pixel. Each word passes the input register and the color-term register
// and lands in the result register. The single line-store RAM is read once per pixel
// and written at most once per pixel.
// Reset is synchronous; it clears the position counters, the pair register, the
// pipeline valids and returns the frame size to 640 by 480. The line store is not cleared.
// A stall on the result side backs up through the stages, so req_pix.ready falls only
// when every stage holds a word.
module rgb_to_yuv420_box_subsample (
   input logic           clock,
   input logic           reset,
   ryuv_pix_if.sink      req_pix,
   ryuv_yuv_if.source    rsp_pix,
   ryuv_csr_if.sink      csr_wr
);
   import ryuv_pkg::*;

   // Clamp a configured size to 1..limit.
   function automatic logic [SIZE_W-1:0] size_clamp(input cfg_word_type v,
                                                    input logic [SIZE_W-1:0] limit);
      logic [SIZE_W-1:0] ext;
      ext = SIZE_W'(v);
      if (ext == '0) begin
         return SIZE_W'(1);
      end
      if (ext > limit) begin
         return limit;
      end
      return ext;
   endfunction

   // Block sum to offset chroma: round the average of four, add 128, clamp to 0..255.
   function automatic pix_type block_value(input logic signed [TERM_W+1:0] s);
      logic signed [TERM_W+1:0] q;
      q = ((s + (TERM_W+2)'(2)) >>> 2) + (TERM_W+2)'(128);
      if (q < 0) begin
         return '0;
      end
      if (q > (TERM_W+2)'(255)) begin
         return '1;
      end
      return q[PIX_W-1:0];
   endfunction

   // ---------------------------------------------------------------------------
   // Configuration registers. Writes are always accepted; unknown indexes are dropped.
   // ---------------------------------------------------------------------------
   cfg_word_type frame_width_ff, frame_width_in;
   cfg_word_type frame_height_ff, frame_height_in;

   assign csr_wr.ready = 1'b1;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_wr.valid) begin
         unique case (csr_wr.index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wr.data;
            CSR_FRAME_HEIGHT: frame_height_in = csr_wr.data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Pipeline handshake. Each stage moves on when the one after it is free.
   // ---------------------------------------------------------------------------
   logic a_valid_ff, a_valid_in;
   logic b_valid_ff, b_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free, b_free, a_free, b_move, a_move, accept;

   assign out_free = !rsp_valid_ff || rsp_pix.ready;
   assign b_move   = b_valid_ff && out_free;
   assign b_free   = !b_valid_ff || out_free;
   assign a_move   = a_valid_ff && b_free;
   assign a_free   = !a_valid_ff || b_free;
   assign accept   = req_pix.valid && a_free;
   assign req_pix.ready = a_free;

   assign a_valid_in   = accept || (a_valid_ff && !b_free);
   assign b_valid_in   = a_move || (b_valid_ff && !out_free);
   assign rsp_valid_in = b_move || (rsp_valid_ff && !rsp_pix.ready);

   // ---------------------------------------------------------------------------
   // Raster position. The counters advance as each pixel is accepted, so every
   // pixel carries its own column and row parity and its end-of-frame flag.
   // ---------------------------------------------------------------------------
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [SIZE_W-1:0] width_eff, height_eff;
   logic              last_col, last_row;

   assign width_eff  = size_clamp(frame_width_ff, SIZE_W'(MAX_WIDTH));
   assign height_eff = size_clamp(frame_height_ff, SIZE_W'(MAX_HEIGHT));
   assign last_col   = (SIZE_W'(col_ff) + SIZE_W'(1)) >= width_eff;
   assign last_row   = (SIZE_W'(row_ff) + SIZE_W'(1)) >= height_eff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stage A: input register.
   // ---------------------------------------------------------------------------
   pix_type              a_red_ff, a_green_ff, a_blue_ff;
   logic                 a_col_odd_ff, a_row_odd_ff, a_fend_ff;
   logic [LINE_AW-1:0]   a_addr_ff;

   // Color terms. The rounded chroma terms are the top bits of the two's-complement sums,
   // which is a floor division by 256.
   logic [17:0]        luma_sum;
   logic signed [17:0] cb_sum, cr_sum;
   logic signed [17:0] red_s, green_s, blue_s;

   assign red_s   = $signed({10'b0, a_red_ff});
   assign green_s = $signed({10'b0, a_green_ff});
   assign blue_s  = $signed({10'b0, a_blue_ff});

   assign luma_sum = 18'(a_red_ff) * 18'd66 + 18'(a_green_ff) * 18'd129
                   + 18'(a_blue_ff) * 18'd25 + 18'd128;
   assign cb_sum   = blue_s * 18'sd112 - red_s * 18'sd38 - green_s * 18'sd74 + 18'sd128;
   assign cr_sum   = red_s * 18'sd112 - green_s * 18'sd94 - blue_s * 18'sd18 + 18'sd128;

   // ---------------------------------------------------------------------------
   // Stage B: luma and chroma terms, line-store read data arrives here.
   // ---------------------------------------------------------------------------
   pix_type                   b_luma_ff;
   logic signed [TERM_W-1:0]  b_cb_ff, b_cr_ff;
   logic                      b_col_odd_ff, b_row_odd_ff, b_fend_ff;
   logic [LINE_AW-1:0]        b_addr_ff;

   // Pair register: chroma terms of the pending even-column pixel.
   logic signed [TERM_W-1:0]  pair_cb_ff, pair_cb_in, pair_cr_ff, pair_cr_in;

   logic [PAIR_W-1:0]         line_rd;
   logic signed [TERM_W:0]    pcb, pcr;
   logic signed [TERM_W+1:0]  blk_cb, blk_cr;
   logic                      line_we;

   ryuv_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (LINE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (b_addr_ff),
      .wr_data ({pcr[TERM_W-1:0], pcb[TERM_W-1:0]}),
      .rd_en   (a_move),
      .rd_addr (a_addr_ff),
      .rd_data (line_rd)
   );

   assign pcb = (TERM_W+1)'(pair_cb_ff) + (TERM_W+1)'(b_cb_ff);
   assign pcr = (TERM_W+1)'(pair_cr_ff) + (TERM_W+1)'(b_cr_ff);

   assign blk_cb = (TERM_W+2)'($signed(line_rd[TERM_W-1:0])) + (TERM_W+2)'(pcb);
   assign blk_cr = (TERM_W+2)'($signed(line_rd[PAIR_W-1:TERM_W])) + (TERM_W+2)'(pcr);

   // Even rows leave their pair sums in the line store for the row below.
   assign line_we = b_move && b_col_odd_ff && !b_row_odd_ff;

   always_comb begin
      pair_cb_in = pair_cb_ff;
      pair_cr_in = pair_cr_ff;
      if (b_move && !b_col_odd_ff) begin
         pair_cb_in = b_cb_ff;
         pair_cr_in = b_cr_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Result register.
   // ---------------------------------------------------------------------------
   pix_type rsp_luma_ff, rsp_cb_ff, rsp_cr_ff;
   logic    rsp_chroma_ff, rsp_fend_ff;
   logic    blk_done;

   assign blk_done = b_col_odd_ff && b_row_odd_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         pair_cb_ff      <= '0;
         pair_cr_ff      <= '0;
         a_valid_ff      <= 1'b0;
         b_valid_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         pair_cb_ff      <= pair_cb_in;
         pair_cr_ff      <= pair_cr_in;
         a_valid_ff      <= a_valid_in;
         b_valid_ff      <= b_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers, loaded as each word moves into the stage.
   always_ff @(posedge clock) begin
      if (accept) begin
         a_red_ff     <= req_pix.red;
         a_green_ff   <= req_pix.green;
         a_blue_ff    <= req_pix.blue;
         a_col_odd_ff <= col_ff[0];
         a_row_odd_ff <= row_ff[0];
         a_fend_ff    <= last_col && last_row;
         a_addr_ff    <= LINE_AW'(col_ff >> 1);
      end
      if (a_move) begin
         b_luma_ff    <= luma_sum[15:8] + pix_type'(16);
         b_cb_ff      <= cb_sum[16:8];
         b_cr_ff      <= cr_sum[16:8];
         b_col_odd_ff <= a_col_odd_ff;
         b_row_odd_ff <= a_row_odd_ff;
         b_fend_ff    <= a_fend_ff;
         b_addr_ff    <= a_addr_ff;
      end
      if (b_move) begin
         rsp_luma_ff   <= b_luma_ff;
         rsp_chroma_ff <= blk_done;
         rsp_cb_ff     <= blk_done ? block_value(blk_cb) : '0;
         rsp_cr_ff     <= blk_done ? block_value(blk_cr) : '0;
         rsp_fend_ff   <= b_fend_ff;
      end
   end

   assign rsp_pix.valid        = rsp_valid_ff;
   assign rsp_pix.luma         = rsp_luma_ff;
   assign rsp_pix.chroma_valid = rsp_chroma_ff;
   assign rsp_pix.blue_diff    = rsp_cb_ff;
   assign rsp_pix.red_diff     = rsp_cr_ff;
   assign rsp_pix.frame_end    = rsp_fend_ff;

endmodule

/* tb/sv/rgb_to_yuv420_box_subsample_test.sv */
// Self-checking testbench for rgb_to_yuv420_box_subsample: streams RGB pixel words,
// predicts luma, 2x2 box chroma and frame end per pixel, and checks every result word.
// Depends on ryuv_pkg, the channel interfaces in ryuv_if.sv and the converter RTL.
module rgb_to_yuv420_box_subsample_test;
   import ryuv_pkg::*;

   // One pixel word on the request side and one result word on the response side.
   typedef struct packed {
      pix_type red;
      pix_type green;
      pix_type blue;
   } rgb_word_type;

   typedef struct packed {
      pix_type luma;
      logic    chroma_valid;
      pix_type blue_diff;
      pix_type red_diff;
      logic    frame_end;
   } yuv_word_type;

   // Cycles to let pass after the last result before a register write or the end.
   localparam int DRAIN_CYCLES   = 8;
   localparam int RANDOM_PIXELS  = 260;
   localparam int QUIET_FROM     = 210;
   localparam int WIDE_PIXELS    = 120;
   localparam int LONG_HOLD      = 80;
   localparam int REPORT_LIMIT   = 10;

   logic clock;
   logic reset;

   ryuv_pix_if req_pix ();
   ryuv_yuv_if rsp_pix ();
   ryuv_csr_if csr_wr ();

   rgb_to_yuv420_box_subsample uut (
      .clock   (clock),
      .reset   (reset),
      .req_pix (req_pix),
      .rsp_pix (rsp_pix),
      .csr_wr  (csr_wr)
   );

   // Pixel words waiting to be offered, and result words predicted but not yet seen.
   rgb_word_type pixel_queue[$];
   yuv_word_type pending_yuv[$];

   int pixels_queued   = 0;
   int pixels_accepted = 0;
   int results_seen    = 0;
   int chroma_blocks   = 0;
   int frames_done     = 0;
   int size_writes     = 0;
   int failures        = 0;
   bit tail_quiet      = 0;

   // Predictor state: the frame size registers as the block holds them, the position of
   // the next pixel, the pending even-column terms and the half-row sums of the last even row.
   cfg_word_type      width_reg;
   cfg_word_type      height_reg;
   int unsigned       col_pos;
   int unsigned       row_pos;
   logic [PAIR_W-1:0] pair_sum;
   logic [PAIR_W-1:0] half_row_sums [LINE_DEPTH];

   always #5 clock = ~clock;

   function automatic int sign9(logic [TERM_W-1:0] v);
      return $signed(v);
   endfunction

   function automatic int clamp_dim(cfg_word_type v, int maxv);
      if (v < 1) return 1;
      return (v > maxv) ? maxv : v;
   endfunction

   // Rounded average of a 2x2 block sum, offset to unsigned and clamped to a byte.
   function automatic pix_type block_average(int s);
      int q;
      q = ((s + 2) >>> 2) + 128;
      if (q < 0) q = 0;
      if (q > 255) q = 255;
      return pix_type'(q);
   endfunction

   // Works out the result word of one accepted pixel and advances the predictor state.
   function automatic yuv_word_type convert_pixel(rgb_word_type px);
      int r, g, b, w, h, cb, cr, pcb, pcr;
      int unsigned idx;
      yuv_word_type res;
      r = px.red;
      g = px.green;
      b = px.blue;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      res = '0;
      res.luma = pix_type'(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16);
      cb = (-38 * r - 74 * g + 112 * b + 128) >>> 8;
      cr = (112 * r - 94 * g - 18 * b + 128) >>> 8;
      if (col_pos % 2 == 0) begin
         pair_sum = {TERM_W'(cr), TERM_W'(cb)};
      end else begin
         pcb = sign9(pair_sum[TERM_W-1:0]) + cb;
         pcr = sign9(pair_sum[PAIR_W-1:TERM_W]) + cr;
         idx = col_pos >> 1;
         if (idx < LINE_DEPTH) begin
            if (row_pos % 2 == 0) begin
               half_row_sums[idx] = {TERM_W'(pcr), TERM_W'(pcb)};
            end else begin
               res.chroma_valid = 1'b1;
               res.blue_diff = block_average(sign9(half_row_sums[idx][TERM_W-1:0]) + pcb);
               res.red_diff  = block_average(sign9(half_row_sums[idx][PAIR_W-1:TERM_W]) + pcr);
            end
         end
      end
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         if (row_pos + 1 >= h) begin
            row_pos = 0;
            res.frame_end = 1'b1;
         end else begin
            row_pos = row_pos + 1;
         end
      end else begin
         col_pos = col_pos + 1;
      end
      return res;
   endfunction

   // Number of pixels from the current position to the end of the frame, under the
   // current sizes. A position already past the last column ends its row on the next pixel.
   function automatic int pixels_to_frame_end();
      int w, h, rest_of_row;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      rest_of_row = (col_pos + 1 >= w) ? 1 : w - col_pos;
      if (row_pos + 1 >= h) return rest_of_row;
      return rest_of_row + (h - row_pos - 1) * w;
   endfunction

   // Mostly uniform colors, with a share of saturated channels so that the
   // corners of the color cube come up often.
   function automatic rgb_word_type random_pixel();
      rgb_word_type px;
      px = 24'($urandom);
      if ($urandom_range(0, 4) == 0) begin
         px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      return px;
   endfunction

   // Small sizes for most frames, now and then an odd one or one at or below the bottom of the legal range.
   function automatic cfg_word_type random_dim();
      case ($urandom_range(0, 9))
         0: begin
            return cfg_word_type'($urandom_range(0, 1));
         end
         1, 2: begin
            return cfg_word_type'(2 * $urandom_range(1, 7) + 1);
         end
         default: begin
            return cfg_word_type'($urandom_range(2, 16));
         end
      endcase
   endfunction

   task automatic queue_pixel(rgb_word_type px);
      pixel_queue.push_back(px);
      pixels_queued++;
   endtask

   task automatic queue_random_pixels(int n);
      repeat (n) queue_pixel(random_pixel());
   endtask

   // Holds the sender back until every queued word has been taken and every expected
   // result has come back, then lets the pipeline settle.
   task automatic wait_idle();
      while (pixels_accepted != pixels_queued || pending_yuv.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write; the predictor takes the new value at the handshake edge.
   task automatic write_reg(csr_index_type idx, cfg_word_type val);
      @(posedge clock);
      csr_wr.valid <= 1'b1;
      csr_wr.index <= idx;
      csr_wr.data  <= val;
      do @(posedge clock); while (!csr_wr.ready);
      csr_wr.valid <= 1'b0;
      if (idx == CSR_FRAME_WIDTH) width_reg = val;
      else height_reg = val;
      size_writes++;
   endtask

   task automatic write_size(cfg_word_type w, cfg_word_type h);
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
   endtask

   task automatic note_failure(string what, yuv_word_type want, yuv_word_type got);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $display("%s at result %0d: expected Y=%0d cv=%0d Cb=%0d Cr=%0d fe=%0d,",
                  what, results_seen, want.luma, want.chroma_valid, want.blue_diff,
                  want.red_diff, want.frame_end);
         $display("   got Y=%0d cv=%0d Cb=%0d Cr=%0d fe=%0d",
                  got.luma, got.chroma_valid, got.blue_diff, got.red_diff, got.frame_end);
      end
   endtask

   // Pixel driver. A new word is offered once the current one is taken or none is up.
   // Every accepted word is handed to the predictor at the edge that accepts it, so
   // the expected results line up with the order the block sees.
   int send_gap = 0;
   always @(posedge clock) begin : pixel_driver
      rgb_word_type px;
      if (reset) begin
         req_pix.valid <= 1'b0;
      end else begin
         if (req_pix.valid && req_pix.ready) begin
            pending_yuv.push_back(convert_pixel({req_pix.red, req_pix.green, req_pix.blue}));
            pixels_accepted++;
         end
         if (!req_pix.valid || req_pix.ready) begin
            if (send_gap > 0) begin
               req_pix.valid <= 1'b0;
               send_gap--;
            end else if (pixel_queue.size() > 0) begin
               px = pixel_queue.pop_front();
               req_pix.valid <= 1'b1;
               req_pix.red   <= px.red;
               req_pix.green <= px.green;
               req_pix.blue  <= px.blue;
               // Occasionally follow this word with an idle burst.
               if (!tail_quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 5);
            end else begin
               req_pix.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and ready driver. Each accepted result word is checked against the
   // oldest prediction. Ready drops in short random bursts, and once, while a large
   // frame is queued, it stays low long enough for the block to fill and stall its input.
   int  stall_left     = 0;
   int  long_hold_left = 0;
   bit  long_hold_done = 0;
   always @(posedge clock) begin : yuv_monitor
      yuv_word_type got, want;
      if (reset) begin
         rsp_pix.ready <= 1'b0;
      end else begin
         if (rsp_pix.valid && rsp_pix.ready) begin
            got = '{luma: rsp_pix.luma, chroma_valid: rsp_pix.chroma_valid,
                    blue_diff: rsp_pix.blue_diff, red_diff: rsp_pix.red_diff,
                    frame_end: rsp_pix.frame_end};
            if (pending_yuv.size() == 0) begin
               note_failure("unexpected result word", '0, got);
            end else begin
               want = pending_yuv.pop_front();
               if (got !== want) note_failure("mismatch", want, got);
               if (want.chroma_valid) chroma_blocks++;
               if (want.frame_end) frames_done++;
            end
            results_seen++;
         end
         if (long_hold_left > 0) begin
            rsp_pix.ready <= 1'b0;
            long_hold_left--;
         end else if (!long_hold_done && pixel_queue.size() > 100) begin
            rsp_pix.ready <= 1'b0;
            long_hold_left = LONG_HOLD - 1;
            long_hold_done = 1;
         end else if (stall_left > 0) begin
            rsp_pix.ready <= 1'b0;
            stall_left--;
         end else if (!tail_quiet && $urandom_range(0, 7) == 0) begin
            rsp_pix.ready <= 1'b0;
            stall_left = $urandom_range(0, 4);
         end else begin
            rsp_pix.ready <= 1'b1;
         end
      end
   end

   // Run limit, sized well above the slowest legal run: at most about 700 words, each
   // under the longest sender gap and receiver stall, plus the settling pauses.
   initial begin
      #5000000;
      $display("status: fail");
      $finish;
   end

   // Main sequence: reset, a short directed part, a frame at the clamped maximum width,
   // then random frames and partial frames with size changes in between.
   initial begin : main_sequence
      int random_count;
      int n;
      clock = 1'b0;
      reset = 1'b1;
      req_pix.valid = 1'b0;
      req_pix.red   = '0;
      req_pix.green = '0;
      req_pix.blue  = '0;
      rsp_pix.ready = 1'b0;
      csr_wr.valid  = 1'b0;
      csr_wr.index  = CSR_FRAME_WIDTH;
      csr_wr.data   = '0;
      width_reg  = FRAME_WIDTH_RESET;
      height_reg = FRAME_HEIGHT_RESET;
      col_pos  = 0;
      row_pos  = 0;
      pair_sum = '0;
      random_count = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // A 4 by 2 frame of the color cube corners: two complete chroma blocks
      // built from the extreme channel values.
      write_size(4, 2);
      queue_pixel('{8'h00, 8'h00, 8'h00});
      queue_pixel('{8'hFF, 8'hFF, 8'hFF});
      queue_pixel('{8'hFF, 8'h00, 8'h00});
      queue_pixel('{8'h00, 8'hFF, 8'h00});
      queue_pixel('{8'h00, 8'h00, 8'hFF});
      queue_pixel('{8'hFF, 8'hFF, 8'h00});
      queue_pixel('{8'h00, 8'hFF, 8'hFF});
      queue_pixel('{8'hFF, 8'h00, 8'hFF});
      wait_idle();

      // A 3 by 3 frame: the trailing odd column and odd row must get no chroma.
      write_size(3, 3);
      queue_random_pixels(9);
      wait_idle();

      // Sizes below the legal range clamp to one, so every pixel ends a frame.
      write_size(0, 0);
      queue_random_pixels(2);
      wait_idle();
      write_size(1, 1);
      queue_random_pixels(1);
      wait_idle();

      // A width above the range clamps to the maximum. The first part of its top row
      // fills the low entries of the line store, so the narrow frames after it only
      // ever read entries that hold data. Shrinking the size in the middle of that row
      // then ends the row on the next pixel, and a short odd row closes the frame.
      write_size(cfg_word_type'(4095), 2);
      queue_random_pixels(WIDE_PIXELS);
      wait_idle();
      write_size(2, 2);
      queue_random_pixels(pixels_to_frame_end());
      wait_idle();

      // Random part. Most chunks run to the end of the frame under the current sizes;
      // the rest stop partway, so the next size write lands mid-frame.
      while (random_count < RANDOM_PIXELS) begin
         if (random_count >= QUIET_FROM) tail_quiet = 1;
         if ($urandom_range(0, 3) != 0) write_reg(CSR_FRAME_WIDTH, random_dim());
         if ($urandom_range(0, 3) != 0) write_reg(CSR_FRAME_HEIGHT, random_dim());
         n = ($urandom_range(0, 3) != 0) ? pixels_to_frame_end() : $urandom_range(1, 24);
         queue_random_pixels(n);
         random_count += n;
         wait_idle();
      end

      $display("covered %0d pixel words in %0d frames with %0d chroma blocks,",
               pixels_accepted, frames_done, chroma_blocks);
      $display("across %0d size register writes including clamped and mid-frame sizes",
               size_writes);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
